/* sv/tdf_pkg.sv */
// ----------------------------------------------------------------------------
// tdf_pkg
// shared widths, codes and types of the trial division factorizer
// ----------------------------------------------------------------------------
package tdf_pkg;

  // payload widths
  localparam int NUM_BITS    = 48;
  localparam int STATUS_BITS = 2;

  // trial divisor stays below sqrt(2^47) + 2, squared value below 2^50
  localparam int DIV_BITS = 25;
  localparam int SQ_BITS  = 2 * DIV_BITS;

  // default for the top level parameter
  localparam int VALUE_BITS_DEF = 48;

  // largest accepted number, 2^47
  localparam logic [NUM_BITS-1:0] MAX_NUMBER = NUM_BITS'(48'h8000_0000_0000);

  // counter width of the bit-serial divider
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_COMPOSITE = 2'd0,
    STATUS_PRIME     = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic done;
    logic exact;
  } div_stat_t;

endpackage

/* sv/tdf_if.sv */
// ----------------------------------------------------------------------------
// tdf_if
// valid/ready channels for numbers in and factors out
// ----------------------------------------------------------------------------
interface tdf_num_if;
  logic                         valid;
  logic                         ready;
  logic [tdf_pkg::NUM_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface tdf_fac_if;
  logic                            valid;
  logic                            ready;
  logic [tdf_pkg::NUM_BITS-1:0]    factor;
  logic                            last;
  logic [tdf_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, output factor, output last, output status, input ready);
  modport sink   (input valid, input factor, input last, input status, output ready);
endinterface

/* sv/tdf_divider.sv */
// ----------------------------------------------------------------------------
// tdf_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdf_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tdf_pkg::NUM_BITS-1:0] dividend,
  input  logic [tdf_pkg::DIV_BITS-1:0] divisor,
  output tdf_pkg::div_stat_t           stat,
  output logic [tdf_pkg::NUM_BITS-1:0] quotient
);

  logic [tdf_pkg::NUM_BITS-1:0] q;
  logic [tdf_pkg::DIV_BITS-1:0] r;
  logic [tdf_pkg::CNT_BITS-1:0] cnt;
  logic                         active;
  logic                         done;
  logic [tdf_pkg::DIV_BITS:0]   r_sh;
  logic [tdf_pkg::DIV_BITS:0]   diff;
  logic                         fits;

  always_comb begin
    r_sh = {r, q[tdf_pkg::NUM_BITS-1]};
    diff = r_sh - {1'b0, divisor};
    fits = (r_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      cnt    <= tdf_pkg::CNT_BITS'(tdf_pkg::NUM_BITS);
    end else if (active) begin
      cnt <= cnt - tdf_pkg::CNT_BITS'(1);
      if (cnt == tdf_pkg::CNT_BITS'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
    end else if (active) begin
      q <= {q[tdf_pkg::NUM_BITS-2:0], fits};
      r <= fits ? diff[tdf_pkg::DIV_BITS-1:0] : r_sh[tdf_pkg::DIV_BITS-1:0];
    end
  end

  assign stat.done  = done;
  assign stat.exact = (r == '0);
  assign quotient   = q;

endmodule

/* sv/trial_division_factorizer.sv */
// ----------------------------------------------------------------------------
// trial_division_factorizer
// prime factorization of one unsigned number by trial division
// ----------------------------------------------------------------------------
// Takes one number and returns its prime factors in ascending order, repeats
// included, one item per factor; the final item has last set. Divisors tried
// are 2, then 3, 5, 7 and on, until the divisor squared exceeds what is left;
// that leftover is the final factor. A prime input gives one item with prime
// status, an input below 2 or above 2^47 one item with factor zero and range
// status. Each trial runs the bit-serial divider and steps through the
// check, divide and wait states; an exact division emits the factor and
// tries the same divisor again. A prime near 2^47 takes some 6e6 odd trials.
// The divisor square is kept by adding 4d+4 per step, so no multiplier is
// involved. The block takes no new number until the last factor is in the
// output register; that register lets the next number enter while the final
// factor waits.
// ----------------------------------------------------------------------------
module trial_division_factorizer #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  tdf_num_if.sink  number_ch,
  tdf_fac_if.source factor_ch
);

  // input bits kept, numbers wider than VALUE_BITS are masked first
  localparam logic [tdf_pkg::NUM_BITS-1:0] ValueMask =
    (VALUE_BITS >= tdf_pkg::NUM_BITS) ? {tdf_pkg::NUM_BITS{1'b1}} :
    tdf_pkg::NUM_BITS'((64'd1 << VALUE_BITS) - 64'd1);

  tdf_pkg::state_t state, state_next;

  // working registers
  logic [tdf_pkg::NUM_BITS-1:0] rem, rem_next;
  logic [tdf_pkg::DIV_BITS-1:0] dvs, dvs_next;
  logic [tdf_pkg::SQ_BITS-1:0]  sq, sq_next;
  logic                         found, found_next;

  // item waiting to go into the output register
  logic [tdf_pkg::NUM_BITS-1:0] pend_factor, pend_factor_next;
  logic                         pend_last, pend_last_next;
  tdf_pkg::status_t             pend_status, pend_status_next;

  // output register
  logic                         out_valid, out_valid_next;
  logic [tdf_pkg::NUM_BITS-1:0] out_factor, out_factor_next;
  logic                         out_last, out_last_next;
  tdf_pkg::status_t             out_status, out_status_next;

  logic                         div_start;
  tdf_pkg::div_stat_t           div_stat;
  logic [tdf_pkg::NUM_BITS-1:0] div_quot;

  logic [tdf_pkg::NUM_BITS-1:0] num_masked;
  logic                         num_bad;
  logic                         take_in;
  logic                         out_free;

  tdf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem),
    .divisor  (dvs),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  assign num_masked = number_ch.number & ValueMask;
  assign num_bad    = (num_masked < tdf_pkg::NUM_BITS'(2)) ||
                      (num_masked > tdf_pkg::MAX_NUMBER);
  assign take_in    = number_ch.valid && number_ch.ready;
  assign out_free   = !out_valid || factor_ch.ready;

  assign number_ch.ready  = (state == tdf_pkg::ST_IDLE);
  assign factor_ch.valid  = out_valid;
  assign factor_ch.factor = out_factor;
  assign factor_ch.last   = out_last;
  assign factor_ch.status = out_status;

  // sequencer
  always_comb begin
    state_next       = state;
    rem_next         = rem;
    dvs_next         = dvs;
    sq_next          = sq;
    found_next       = found;
    pend_factor_next = pend_factor;
    pend_last_next   = pend_last;
    pend_status_next = pend_status;
    out_valid_next   = out_valid && !factor_ch.ready;
    out_factor_next  = out_factor;
    out_last_next    = out_last;
    out_status_next  = out_status;
    div_start        = 1'b0;

    case (state)
      tdf_pkg::ST_IDLE: begin
        if (take_in) begin
          if (num_bad) begin
            pend_factor_next = '0;
            pend_last_next   = 1'b1;
            pend_status_next = tdf_pkg::STATUS_RANGE;
            state_next       = tdf_pkg::ST_EMIT;
          end else begin
            rem_next   = num_masked;
            dvs_next   = tdf_pkg::DIV_BITS'(2);
            sq_next    = tdf_pkg::SQ_BITS'(4);
            found_next = 1'b0;
            state_next = tdf_pkg::ST_CHECK;
          end
        end
      end

      tdf_pkg::ST_CHECK: begin
        // keep trying while divisor squared fits in what is left
        if (sq <= {{(tdf_pkg::SQ_BITS-tdf_pkg::NUM_BITS){1'b0}}, rem}) begin
          state_next = tdf_pkg::ST_DIVIDE;
        end else begin
          pend_factor_next = rem;
          pend_last_next   = 1'b1;
          pend_status_next = found ? tdf_pkg::STATUS_COMPOSITE : tdf_pkg::STATUS_PRIME;
          state_next       = tdf_pkg::ST_EMIT;
        end
      end

      tdf_pkg::ST_DIVIDE: begin
        div_start  = 1'b1;
        state_next = tdf_pkg::ST_WAIT;
      end

      tdf_pkg::ST_WAIT: begin
        if (div_stat.done) begin
          if (div_stat.exact) begin
            // divisor fits: report it and divide it out, same divisor next
            rem_next         = div_quot;
            found_next       = 1'b1;
            pend_factor_next = {{(tdf_pkg::NUM_BITS-tdf_pkg::DIV_BITS){1'b0}}, dvs};
            pend_last_next   = 1'b0;
            pend_status_next = tdf_pkg::STATUS_COMPOSITE;
            state_next       = tdf_pkg::ST_EMIT;
          end else begin
            if (dvs == tdf_pkg::DIV_BITS'(2)) begin
              dvs_next = tdf_pkg::DIV_BITS'(3);
              sq_next  = tdf_pkg::SQ_BITS'(9);
            end else begin
              // (d+2)^2 = d^2 + 4d + 4
              dvs_next = dvs + tdf_pkg::DIV_BITS'(2);
              sq_next  = sq + {{(tdf_pkg::SQ_BITS-tdf_pkg::DIV_BITS-2){1'b0}}, dvs, 2'b00}
                         + tdf_pkg::SQ_BITS'(4);
            end
            state_next = tdf_pkg::ST_CHECK;
          end
        end
      end

      tdf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_factor_next = pend_factor;
          out_last_next   = pend_last;
          out_status_next = pend_status;
          state_next      = pend_last ? tdf_pkg::ST_IDLE : tdf_pkg::ST_CHECK;
        end
      end

      default: state_next = tdf_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload and working values
  always_ff @(posedge clk) begin
    rem         <= rem_next;
    dvs         <= dvs_next;
    sq          <= sq_next;
    found       <= found_next;
    pend_factor <= pend_factor_next;
    pend_last   <= pend_last_next;
    pend_status <= pend_status_next;
    out_factor  <= out_factor_next;
    out_last    <= out_last_next;
    out_status  <= out_status_next;
  end

endmodule
